// File: rtl/core/pse_pkg.sv
`default_nettype none

package pse_pkg;

  // operand and result width
  localparam int DataW = 32;

  // operator codes
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_DIVZERO   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // token sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_DIV  = 2'd2,
    FSM_EMIT = 2'd3
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/pse_ram.sv
`default_nettype none

module pse_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pse_div.sv
`default_nettype none

module pse_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pse_pkg::DataW-1:0]   dividend_i,
  input  wire logic [pse_pkg::DataW-1:0]   divisor_i,
  output logic                             done_o,
  output logic      [pse_pkg::DataW-1:0]   quotient_o
);

  import pse_pkg::*;

  localparam int StepW = $clog2(DataW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  // one restoring step per cycle on the magnitudes
  always_comb begin
    trial  = {rem_q, quo_q[DataW-1]};
    diff   = trial - {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i[DataW-1] ? (~dividend_i + DataW'(1)) : dividend_i;
      den_d  = divisor_i[DataW-1] ? (~divisor_i + DataW'(1)) : divisor_i;
      neg_d  = dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // sign fix-up of the quotient
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + DataW'(1)) : quo_q;

endmodule

`default_nettype wire

// File: rtl/core/postfix_stack_evaluator_core.sv
// Push: taken in FSM_IDLE. Add, subtract, multiply: stack memory read, then FSM_EXEC.
// Divide: read, then FSM_EXEC starts the one-bit-per-cycle restoring divider (32 steps).
// A result goes through FSM_EMIT into the output register and waits there for out_ready_i.
// Reset clears the stack count and the control state; the stack memory is not cleared,
// only entries below the count are ever read.
`default_nettype none

module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             mode_i,
  input  wire logic signed [pse_pkg::DataW-1:0] operand_value_i,
  input  wire logic        [1:0]                operator_code_i,
  input  wire logic                             last_token_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed      [pse_pkg::DataW-1:0] result_value_o,
  output logic             [1:0]                status_o
);

  import pse_pkg::*;

  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] top_q, top_d;
  logic [DataW-1:0] res_q, res_d;
  status_e          sts_q, sts_d;
  op_e              op_q, op_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_res_q, out_res_d;
  status_e          out_sts_q, out_sts_d;

  logic             accept;
  logic             full;
  logic             underflow;
  logic             out_free;
  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  logic [DataW-1:0] mem_rdata;
  logic [DataW-1:0] prod;
  logic             div_start;
  logic             div_done;
  logic [DataW-1:0] div_quo;

  assign accept    = in_valid_i && in_ready_o;
  assign full      = (cnt_q == CntW'(STACK_DEPTH));
  assign underflow = (cnt_q < CntW'(2));
  assign out_free  = !out_valid_q || out_ready_i;
  assign mem_waddr = AddrW'(cnt_q - CntW'(1));
  assign mem_raddr = AddrW'(cnt_q - CntW'(2));
  assign prod      = mem_rdata * top_q;

  // entries below the top of stack; the top lives in top_q
  pse_ram #(
    .Width (DataW),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (top_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // signed truncating divide, next below top over top
  pse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mem_rdata),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            state_d = (full || last_token_i) ? FSM_EMIT : FSM_IDLE;
          end else begin
            state_d = underflow ? FSM_EMIT : FSM_EXEC;
          end
        end
      end
      FSM_EXEC: begin
        if (op_q == OP_DIV) begin
          state_d = (top_q == '0) ? FSM_EMIT : FSM_DIV;
        end else begin
          state_d = last_q ? FSM_EMIT : FSM_IDLE;
        end
      end
      FSM_DIV: begin
        if (div_done) begin
          state_d = last_q ? FSM_EMIT : FSM_IDLE;
        end
      end
      FSM_EMIT: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = in_valid_i && !mode_i && !full && (cnt_q != '0);
        mem_re     = in_valid_i && mode_i && !underflow;
      end
      FSM_EXEC: begin
        div_start = (op_q == OP_DIV) && (top_q != '0);
      end
      FSM_DIV:  ;
      FSM_EMIT: ;
      default:  ;
    endcase
  end

  // stack and result datapath
  always_comb begin
    cnt_d       = cnt_q;
    top_d       = top_q;
    res_d       = res_q;
    sts_d       = sts_q;
    op_d        = op_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_sts_d   = out_sts_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            if (full) begin
              res_d = '0;
              sts_d = ST_FULL;
              cnt_d = '0;
            end else begin
              top_d = operand_value_i;
              cnt_d = cnt_q + CntW'(1);
              if (last_token_i) begin
                res_d = operand_value_i;
                sts_d = ST_OK;
                cnt_d = '0;
              end
            end
          end else if (underflow) begin
            res_d = '0;
            sts_d = ST_UNDERFLOW;
            cnt_d = '0;
          end else begin
            op_d   = op_e'(operator_code_i);
            last_d = last_token_i;
          end
        end
      end
      FSM_EXEC: begin
        if (op_q == OP_DIV) begin
          if (top_q == '0) begin
            res_d = '0;
            sts_d = ST_DIVZERO;
            cnt_d = '0;
          end
        end else begin
          case (op_q)
            OP_MUL:  top_d = prod;
            OP_ADD:  top_d = mem_rdata + top_q;
            default: top_d = mem_rdata - top_q;
          endcase
          cnt_d = cnt_q - CntW'(1);
          if (last_q) begin
            res_d = top_d;
            sts_d = ST_OK;
            cnt_d = '0;
          end
        end
      end
      FSM_DIV: begin
        if (div_done) begin
          top_d = div_quo;
          cnt_d = cnt_q - CntW'(1);
          if (last_q) begin
            res_d = div_quo;
            sts_d = ST_OK;
            cnt_d = '0;
          end
        end
      end
      FSM_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_sts_d   = sts_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    res_q     <= res_d;
    sts_q     <= sts_d;
    op_q      <= op_d;
    last_q    <= last_d;
    out_res_q <= out_res_d;
    out_sts_q <= out_sts_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_sts_q;

endmodule

`default_nettype wire
